[rtl/core/a85e_pkg.sv]
// Shared constants and types for the ASCII85 stream encoder.
package a85e_pkg;

    // Input kind codes carried on tuser
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Line limit after reset
    localparam logic [7:0] DEF_LINE_LIMIT = 8'd75;

    // Output characters
    localparam logic [7:0] CHAR_BASE  = 8'h21;  // '!'
    localparam logic [7:0] CHAR_ZERO  = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_NL    = 8'h0A;  // newline
    localparam logic [7:0] CHAR_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'

    // Group geometry
    localparam int unsigned GROUP_DIGITS = 5;
    localparam int unsigned MAX_CHARS    = 7;
    localparam logic [1:0]  LAST_SLOT    = 2'd3;

    // Divide by 85: q = (v * RECIP_85) >> RECIP_SHIFT is exact for every 32-bit v
    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [6:0]  DIGIT_BASE  = 7'd85;

    // Describes the characters one group or trailer produces
    typedef struct packed {
        logic [2:0] ndig;     // digit slots to emit (a zero group uses one slot for 'z')
        logic       zero;     // all-zero full group
        logic       nl;       // newline after the group
        logic       trl;      // end-of-stream trailer after the digits
    } job_meta_t;

endpackage

[rtl/core/ascii85_stream_encoder.sv]
// ASCII85 stream encoder: byte gathering, base-85 conversion pipeline and character output.
//
// Usage:
//   The slave stream takes one item per transfer: tuser[0] selects a data byte (0)
//   or an end-of-stream marker (1), and tdata carries the byte. Every fourth data byte
//   closes a 32-bit big-endian group, which yields 'z' or five base-85 digits and
//   possibly a newline once the line count passes line_limit. An end marker flushes a
//   partial group of n bytes as n+1 digits, then sends "~>" and a newline.
//   The master stream sends one character per transfer; tlast marks the final
//   character that one input item caused. Bytes that do not close a group cause none.
//   The cfg channel writes line_limit (always ready); write it only while idle.
// Pipeline and rate:
//   A group enters a five-stage divide-by-85 pipeline (a 32x32 reciprocal multiply in
//   each of the first four stages); its first character is valid on the master side once
//   the job leaves the last stage and loads into the output register. The output register
//   sends one character per cycle while m_tready is high, so the single-character port
//   limits nonzero groups. Other bytes are taken one per cycle while s_tready is high.
// Reset and stall:
//   rst_n clears the group, line count, pipeline and output; line_limit returns to 75.
//   When the receiver stalls, the pipeline holds behind the output register, an empty
//   first stage can still take a job, and then tready drops; nothing is dropped or repeated.
module ascii85_stream_encoder
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,     // [7:0] line_limit

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] byte_value
    input  logic [0:0] s_tuser,      // [0] kind

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_char
    output logic       m_tlast
);

    // ------------------------------------------------------------------
    // Configuration and group state
    // ------------------------------------------------------------------
    logic [7:0] line_limit_reg;
    logic [7:0] group_bytes_reg [0:2];
    logic [1:0] fill_reg;
    logic [7:0] line_count_reg;

    // Pipeline stage registers: a holds the running quotient, b the previous one
    logic                    pipe_valid_reg [1:5];
    logic [31:0]             pipe_a_reg     [1:5];
    logic [31:0]             pipe_b_reg     [2:5];
    logic [6:0]              pipe_dig_reg   [3:5][2:4];
    a85e_pkg::job_meta_t     pipe_meta_reg  [1:5];

    // Output register: a short queue of characters, head at slot 0
    logic [7:0] emit_char_reg [0:6];
    logic [2:0] emit_cnt_reg;

    logic                s_accept;
    logic                m_take;
    logic                pipe_en;
    logic                emit_load;
    logic                in_kind;
    logic                job_valid;
    logic [31:0]         job_value;
    a85e_pkg::job_meta_t job_meta;
    logic [31:0]         full_value;
    logic                full_zero;
    logic [8:0]          line_sum;
    logic                line_wrap;

    logic [63:0] stage_prod [1:4];
    logic [31:0] stage_q    [1:4];
    logic [6:0]  stage_rem  [2:5];

    logic [6:0]  dig_val [0:4];
    logic [7:0]  load_char [0:6];
    logic [2:0]  emit_total;

    assign cfg_ready = 1'b1;

    // Stall-all pipeline: advance whenever the last stage is empty or hands off
    assign emit_load = pipe_valid_reg[5]
                     && ((emit_cnt_reg == 3'd0) || ((emit_cnt_reg == 3'd1) && m_take));
    assign pipe_en   = !pipe_valid_reg[5] || emit_load;

    assign s_tready  = pipe_en || !pipe_valid_reg[1];
    assign s_accept  = s_tvalid && s_tready;
    assign m_take    = m_tvalid && m_tready;
    assign in_kind   = s_tuser[0];

    // ------------------------------------------------------------------
    // Group assembly and line accounting
    // ------------------------------------------------------------------
    always_comb
    begin
        full_value = {group_bytes_reg[0], group_bytes_reg[1], group_bytes_reg[2], s_tdata};
        full_zero  = (full_value == 32'd0);
        line_sum   = {1'b0, line_count_reg} + (full_zero ? 9'd1 : 9'd5);
        line_wrap  = (line_sum > {1'b0, line_limit_reg});

        job_meta   = '0;
        if (in_kind == a85e_pkg::KIND_END)
        begin
            // Pad the partial group with zero bytes
            job_valid     = 1'b1;
            job_value     = {(fill_reg > 2'd0) ? group_bytes_reg[0] : 8'd0,
                             (fill_reg > 2'd1) ? group_bytes_reg[1] : 8'd0,
                             (fill_reg > 2'd2) ? group_bytes_reg[2] : 8'd0,
                             8'd0};
            job_meta.ndig = (fill_reg == 2'd0) ? 3'd0 : ({1'b0, fill_reg} + 3'd1);
            job_meta.trl  = 1'b1;
        end
        else
        begin
            job_valid     = (fill_reg == a85e_pkg::LAST_SLOT);
            job_value     = full_value;
            job_meta.ndig = full_zero ? 3'd1 : 3'd5;
            job_meta.zero = full_zero;
            job_meta.nl   = line_wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= a85e_pkg::DEF_LINE_LIMIT;
            fill_reg       <= 2'd0;
            line_count_reg <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                line_limit_reg <= cfg_data;
            end
            if (s_accept)
            begin
                if (in_kind == a85e_pkg::KIND_END)
                begin
                    fill_reg       <= 2'd0;
                    line_count_reg <= 8'd0;
                end
                else
                begin
                    fill_reg <= fill_reg + 2'd1;
                    if (fill_reg == a85e_pkg::LAST_SLOT)
                    begin
                        line_count_reg <= line_wrap ? 8'd0 : line_sum[7:0];
                    end
                end
            end
        end
    end

    // Hold the first three bytes of the group; the fourth goes straight into the pipeline
    always_ff @(posedge clk)
    begin
        if (s_accept && (in_kind == a85e_pkg::KIND_DATA) && (fill_reg != a85e_pkg::LAST_SLOT))
        begin
            group_bytes_reg[fill_reg] <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Divide-by-85 pipeline: one quotient per stage, remainder one stage later
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 1; k <= 4; k++)
        begin
            stage_prod[k] = {32'd0, pipe_a_reg[k]} * {32'd0, a85e_pkg::RECIP_85};
            stage_q[k]    = {6'd0, stage_prod[k][63:a85e_pkg::RECIP_SHIFT]};
        end
        // The remainder is below 85, so the low 7 bits of b - 85*a are exact
        for (int k = 2; k <= 5; k++)
        begin
            stage_rem[k] = pipe_b_reg[k][6:0] - 7'(pipe_a_reg[k][6:0] * a85e_pkg::DIGIT_BASE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 5; k++)
            begin
                pipe_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (s_accept)
            begin
                pipe_valid_reg[1] <= job_valid;
            end
            else if (pipe_en)
            begin
                pipe_valid_reg[1] <= 1'b0;
            end
            if (pipe_en)
            begin
                for (int k = 1; k <= 4; k++)
                begin
                    pipe_valid_reg[k + 1] <= pipe_valid_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pipe_a_reg[1]    <= job_value;
            pipe_meta_reg[1] <= job_meta;
        end
        if (pipe_en)
        begin
            for (int k = 1; k <= 4; k++)
            begin
                pipe_a_reg[k + 1]    <= stage_q[k];
                pipe_b_reg[k + 1]    <= pipe_a_reg[k];
                pipe_meta_reg[k + 1] <= pipe_meta_reg[k];
            end
            pipe_dig_reg[3][4] <= stage_rem[2];
            pipe_dig_reg[4][4] <= pipe_dig_reg[3][4];
            pipe_dig_reg[4][3] <= stage_rem[3];
            pipe_dig_reg[5][4] <= pipe_dig_reg[4][4];
            pipe_dig_reg[5][3] <= pipe_dig_reg[4][3];
            pipe_dig_reg[5][2] <= stage_rem[4];
        end
    end

    // ------------------------------------------------------------------
    // Character list for the job leaving the last stage
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [2:0] pp;
        logic [2:0] tail;

        dig_val[0] = pipe_a_reg[5][6:0];
        dig_val[1] = stage_rem[5];
        dig_val[2] = pipe_dig_reg[5][2];
        dig_val[3] = pipe_dig_reg[5][3];
        dig_val[4] = pipe_dig_reg[5][4];

        emit_total = pipe_meta_reg[5].ndig
                   + (pipe_meta_reg[5].nl  ? 3'd1 : 3'd0)
                   + (pipe_meta_reg[5].trl ? 3'd3 : 3'd0);

        for (int p = 0; p < a85e_pkg::MAX_CHARS; p++)
        begin
            pp   = 3'(p);
            tail = pp - pipe_meta_reg[5].ndig;
            if (pp < pipe_meta_reg[5].ndig)
            begin
                if (pipe_meta_reg[5].zero)
                begin
                    load_char[p] = a85e_pkg::CHAR_ZERO;
                end
                else
                begin
                    load_char[p] = {1'b0, dig_val[pp]} + a85e_pkg::CHAR_BASE;
                end
            end
            else if (pipe_meta_reg[5].nl)
            begin
                load_char[p] = a85e_pkg::CHAR_NL;
            end
            else if (tail == 3'd0)
            begin
                load_char[p] = a85e_pkg::CHAR_TILDE;
            end
            else if (tail == 3'd1)
            begin
                load_char[p] = a85e_pkg::CHAR_GT;
            end
            else
            begin
                load_char[p] = a85e_pkg::CHAR_NL;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a whole job, shift one character per transfer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_cnt_reg <= 3'd0;
        end
        else if (emit_load)
        begin
            emit_cnt_reg <= emit_total;
        end
        else if (m_take)
        begin
            emit_cnt_reg <= emit_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            for (int p = 0; p < a85e_pkg::MAX_CHARS; p++)
            begin
                emit_char_reg[p] <= load_char[p];
            end
        end
        else if (m_take)
        begin
            for (int p = 0; p < a85e_pkg::MAX_CHARS - 1; p++)
            begin
                emit_char_reg[p] <= emit_char_reg[p + 1];
            end
        end
    end

    assign m_tvalid = (emit_cnt_reg != 3'd0);
    assign m_tdata  = emit_char_reg[0];
    assign m_tlast  = (emit_cnt_reg == 3'd1);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_load_shows_char: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> m_tvalid)
        else $error("loaded job did not reach the output");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (in_kind == a85e_pkg::KIND_END)) |=>
            ((fill_reg == 2'd0) && (line_count_reg == 8'd0)))
        else $error("end of stream left group or line state behind");

    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg[5] |-> (emit_total != 3'd0))
        else $error("job with no characters in last stage");

    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_take && m_tlast && !pipe_valid_reg[5]) |=> !m_tvalid)
        else $error("output still valid after draining with no job waiting");

endmodule
